### hdl/itp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Infix-to-postfix package
// Shared types, character codes and precedence helpers for the converter.
// ----------------------------------------------------------------------------
package itp_pkg;

   localparam int STACK_DEPTH_DEF = 32;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_MUL   = 8'h2A;
   localparam logic [7:0] CH_ADD   = 8'h2B;
   localparam logic [7:0] CH_SUB   = 8'h2D;
   localparam logic [7:0] CH_DIV   = 8'h2F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UPA   = 8'h41;
   localparam logic [7:0] CH_UPZ   = 8'h5A;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [1:0] FAULT_NONE      = 2'd0;
   localparam logic [1:0] FAULT_OVERFLOW  = 2'd1;
   localparam logic [1:0] FAULT_UNMATCHED = 2'd2;

   localparam logic [1:0] PREC_MULDIV = 2'd3;
   localparam logic [1:0] PREC_ADDSUB = 2'd2;
   localparam logic [1:0] PREC_LPAR   = 2'd1;
   localparam logic [1:0] PREC_OTHER  = 2'd0;

   typedef struct packed {
      logic [7:0] symbol;
      logic       expr_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_symbol;
      logic       run_last;
      logic       expr_done;
      logic [1:0] fault;
   } rsp_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic       rd;
      logic [7:0] wdata;
   } stk_cmd_type;

   typedef struct packed {
      logic       empty;
      logic       full;
      logic [7:0] top;
   } stk_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_READ,
      ST_TEST,
      ST_PUSH,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MODE_CLOSE,
      MODE_OPER,
      MODE_FLUSH
   } mode_type;

   function automatic logic [1:0] prec_of(input logic [7:0] c);
      logic [1:0] p;
      p = PREC_OTHER;
      if (c == CH_MUL || c == CH_DIV) begin
         p = PREC_MULDIV;
      end else if (c == CH_ADD || c == CH_SUB) begin
         p = PREC_ADDSUB;
      end else if (c == CH_LPAR) begin
         p = PREC_LPAR;
      end
      return p;
   endfunction

   function automatic logic is_operand(input logic [7:0] c);
      return ((c >= CH_UPA) && (c <= CH_UPZ)) || ((c >= CH_ZERO) && (c <= CH_NINE));
   endfunction

endpackage

### hdl/itp_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operator stack
// Stack memory with an occupancy count and a registered read of the top entry.
// ----------------------------------------------------------------------------
module itp_stack
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  stk_cmd_type  cmd,
   output stk_stat_type stat
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   logic [7:0]        mem_ff [STACK_DEPTH];
   logic [7:0]        rdata_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [CNT_W-1:0]  count_dec;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;

   assign count_dec = count_ff - CNT_W'(1);
   assign rd_addr   = count_dec[ADDR_W-1:0];
   assign wr_addr   = count_ff[ADDR_W-1:0];

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.pop) begin
         count_in = count_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem_ff[wr_addr] <= cmd.wdata;
      end
      if (cmd.rd) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_W'(STACK_DEPTH));
   assign stat.top   = rdata_ff;

endmodule

### hdl/itp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conversion sequencer
// Classifies each character and walks the operator stack one entry at a time.
// ----------------------------------------------------------------------------
module itp_ctrl
   import itp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_type      req_data,
   input  logic         out_free,
   output logic         emit_valid,
   output rsp_type      emit_data,
   output stk_cmd_type  stk_cmd,
   input  stk_stat_type stk_stat
);

   state_type  state_ff, state_in;
   mode_type   mode_ff, mode_in;
   logic [7:0] sym_ff;
   logic       last_ff;
   logic       pend_valid_ff, pend_valid_in;
   rsp_type    pend_ff, pend_in;
   logic       can_gen;
   logic       gen;
   logic [7:0] gen_sym;
   logic [1:0] gen_fault;
   state_type  after_state;
   logic       req_accept;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_FLUSH;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      if (req_accept) begin
         sym_ff  <= req_data.symbol;
         last_ff <= req_data.expr_end;
      end
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      emit_valid    = 1'b0;
      emit_data     = pend_ff;
      stk_cmd       = '0;
      stk_cmd.wdata = sym_ff;
      gen           = 1'b0;
      gen_sym       = CH_NUL;
      gen_fault     = FAULT_NONE;
      // A new result pushes the held one out, so it needs the output register.
      can_gen       = !pend_valid_ff || out_free;
      // With the end mark set the stack is flushed once the character is done.
      after_state   = last_ff ? ST_READ : ST_FINISH;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (sym_ff == CH_SPACE) begin
               mode_in  = MODE_FLUSH;
               state_in = after_state;
            end else if (is_operand(sym_ff)) begin
               if (can_gen) begin
                  gen      = 1'b1;
                  gen_sym  = sym_ff;
                  mode_in  = MODE_FLUSH;
                  state_in = after_state;
               end
            end else if (sym_ff == CH_LPAR) begin
               state_in = ST_PUSH;
            end else if (sym_ff == CH_RPAR) begin
               mode_in  = MODE_CLOSE;
               state_in = ST_READ;
            end else begin
               mode_in  = MODE_OPER;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (stk_stat.empty) begin
               unique case (mode_ff)
                  MODE_CLOSE: begin
                     if (can_gen) begin
                        gen       = 1'b1;
                        gen_fault = FAULT_UNMATCHED;
                        mode_in   = MODE_FLUSH;
                        state_in  = after_state;
                     end
                  end
                  MODE_OPER:  state_in = ST_PUSH;
                  default:    state_in = ST_FINISH;
               endcase
            end else begin
               stk_cmd.rd = 1'b1;
               state_in   = ST_TEST;
            end
         end
         ST_TEST: begin
            unique case (mode_ff)
               MODE_CLOSE: begin
                  if (stk_stat.top == CH_LPAR) begin
                     stk_cmd.pop = 1'b1;
                     mode_in     = MODE_FLUSH;
                     state_in    = after_state;
                  end else if (can_gen) begin
                     gen         = 1'b1;
                     gen_sym     = stk_stat.top;
                     stk_cmd.pop = 1'b1;
                     state_in    = ST_READ;
                  end
               end
               MODE_OPER: begin
                  if (prec_of(stk_stat.top) >= prec_of(sym_ff)) begin
                     if (can_gen) begin
                        gen         = 1'b1;
                        gen_sym     = stk_stat.top;
                        stk_cmd.pop = 1'b1;
                        state_in    = ST_READ;
                     end
                  end else begin
                     state_in = ST_PUSH;
                  end
               end
               default: begin
                  if (can_gen) begin
                     gen         = 1'b1;
                     gen_sym     = stk_stat.top;
                     stk_cmd.pop = 1'b1;
                     state_in    = ST_READ;
                  end
               end
            endcase
         end
         ST_PUSH: begin
            if (stk_stat.full) begin
               if (can_gen) begin
                  gen       = 1'b1;
                  gen_fault = FAULT_OVERFLOW;
                  mode_in   = MODE_FLUSH;
                  state_in  = after_state;
               end
            end else begin
               stk_cmd.push = 1'b1;
               mode_in      = MODE_FLUSH;
               state_in     = after_state;
            end
         end
         ST_FINISH: begin
            if (pend_valid_ff) begin
               if (out_free) begin
                  emit_valid          = 1'b1;
                  emit_data.run_last  = 1'b1;
                  emit_data.expr_done = last_ff;
                  pend_valid_in       = 1'b0;
                  state_in            = ST_IDLE;
               end
            end else if (last_ff) begin
               if (out_free) begin
                  emit_valid           = 1'b1;
                  emit_data.out_symbol = CH_NUL;
                  emit_data.fault      = FAULT_NONE;
                  emit_data.run_last   = 1'b1;
                  emit_data.expr_done  = 1'b1;
                  state_in             = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // The newest result is held back until it is known whether more follow.
      if (gen) begin
         if (pend_valid_ff) begin
            emit_valid = 1'b1;
         end
         pend_valid_in        = 1'b1;
         pend_in.out_symbol   = gen_sym;
         pend_in.run_last     = 1'b0;
         pend_in.expr_done    = 1'b0;
         pend_in.fault        = gen_fault;
      end
   end

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held result left over at end of request");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      emit_valid |-> out_free)
      else $error("result emitted while output register is occupied");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      stk_cmd.push |-> !stk_stat.full)
      else $error("push onto a full stack");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      stk_cmd.pop |-> (!stk_stat.empty && (state_ff == ST_TEST)))
      else $error("pop without a fetched top entry");

endmodule

### hdl/infix_to_postfix_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Infix-to-postfix converter
// Shunting-yard conversion of a character stream with an operator stack.
// ----------------------------------------------------------------------------
// Usage: each request carries one ASCII character and an end-of-expression
// flag. Each request yields zero or more results on the rsp channel; run_last
// marks the final result of a request and expr_done the final result of an
// expression. Stack overflow and an unmatched closing parenthesis come out
// as results with a zero symbol and a nonzero fault code.
//
// The block works on one request at a time and holds req_stall high until
// all of its results are in the output register. A request is classified
// first; an operator or a closing parenthesis then walks the stack, and each
// entry popped costs a read of the stack top through the registered memory
// and a compare. An open parenthesis, and an operator that stops on a weaker
// entry or an empty stack, is pushed last. The end flag adds a final flush
// of the stack and an empty check before the block is free again.
//
// Results are held back one place so that the last one can be flagged, and
// a stalled receiver simply freezes the sequencer until the output register
// frees up. Synchronous reset empties the stack and drops any pending result.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter
   import itp_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   stk_cmd_type  stk_cmd;
   stk_stat_type stk_stat;
   logic         emit_valid;
   rsp_type      emit_data;
   logic         out_free;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff;

   // The output register can take a new result when it is empty or draining.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   itp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .out_free   (out_free),
      .emit_valid (emit_valid),
      .emit_data  (emit_data),
      .stk_cmd    (stk_cmd),
      .stk_stat   (stk_stat)
   );

   itp_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stk_cmd),
      .stat  (stk_stat)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_valid) begin
         rsp_data_ff <= emit_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
